FILE: design/sb64_pkg.sv
`default_nettype none
package sb64_pkg;

    // End-of-text status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
    localparam logic [2:0] ST_BAD_CHAR   = 3'd2;
    localparam logic [2:0] ST_BAD_PAD    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;
    localparam logic [2:0] ST_AFTER_NL   = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [12:0] CAP_RESET = 13'd64;

    // One unit of work for the back end: a decoded quad or an end status
    typedef struct packed {
        logic        is_end;
        logic [23:0] triple;
        logic [1:0]  nbytes;
        logic [2:0]  status;
        logic [12:0] count;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage
`default_nettype wire

FILE: design/sb64_fifo.sv
`default_nettype none
module sb64_fifo
    import sb64_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_job      i_job,
    input  wire logic      i_pop,
    output t_job           o_job,
    output t_q_status      o_status
);

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full job queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty job queue");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.full || o_status.empty) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

FILE: design/sb64_front.sv
`default_nettype none
module sb64_front
    import sb64_pkg::*;
#(
    parameter int MAX_CAPACITY = 4096
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_is_end,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [12:0] i_out_capacity,
    input  wire logic        i_cfg_valid,
    input  wire t_q_status   i_q,
    output logic             o_push,
    output t_job             o_job
);

    localparam logic [16:0] MaxCap = 17'(MAX_CAPACITY);

    logic [12:0] r_cap;
    logic [17:0] r_acc,  n_acc;
    logic [1:0]  r_qpos, n_qpos;
    logic [1:0]  r_pad,  n_pad;
    logic [1:0]  r_len,  n_len;
    logic [1:0]  r_nlr,  n_nlr;
    logic        r_seen, n_seen;
    logic        r_tail, n_tail;
    logic [2:0]  r_err,  n_err;
    logic [12:0] r_bp,   n_bp;

    logic [12:0] cap;

    // {invalid, value}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= "A" && c <= "Z") begin
            v = 7'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            v = 7'(c - "a" + 8'd26);
        end else if (c >= "0" && c <= "9") begin
            v = 7'(c - "0" + 8'd52);
        end else if (c == "+") begin
            v = 7'd62;
        end else if (c == "/") begin
            v = 7'd63;
        end
        return v;
    endfunction

    assign cap        = ({4'b0, r_cap} > MaxCap) ? MaxCap[12:0] : r_cap;
    assign o_in_ready = !i_q.full;

    always_comb begin
        logic       nl;
        logic [5:0] sx;
        logic [6:0] v;
        logic [1:0] want;
        logic [12:0] room;
        logic [1:0] nout;

        n_acc  = r_acc;
        n_qpos = r_qpos;
        n_pad  = r_pad;
        n_len  = r_len;
        n_nlr  = r_nlr;
        n_seen = r_seen;
        n_tail = r_tail;
        n_err  = r_err;
        n_bp   = r_bp;
        o_push = 1'b0;
        o_job  = '0;
        nl     = (i_char_code == 8'h0D) || (i_char_code == 8'h0A);
        sx     = '0;
        v      = sextet_of(i_char_code);
        want   = '0;
        room   = '0;
        nout   = '0;

        if (i_in_valid && o_in_ready) begin
            if (i_is_end) begin
                o_push       = 1'b1;
                o_job.is_end = 1'b1;
                o_job.status = (!r_seen || r_len != 2'd0) ? ST_BAD_LENGTH : r_err;
                o_job.count  = r_bp;
                n_acc  = '0;
                n_qpos = '0;
                n_pad  = '0;
                n_len  = '0;
                n_nlr  = '0;
                n_seen = 1'b0;
                n_tail = 1'b0;
                n_err  = ST_OK;
                n_bp   = '0;
            end else if (nl) begin
                n_tail = 1'b1;
                n_nlr  = r_tail ? r_nlr + 2'd1 : 2'd1;
            end else begin
                if (r_tail) begin
                    if (r_pad != 2'd0 && n_err == ST_OK) n_err = ST_BAD_PAD;
                    if (n_err == ST_OK) n_err = ST_AFTER_NL;
                    n_len  = n_len + r_nlr;
                    n_tail = 1'b0;
                    n_nlr  = '0;
                end
                n_seen = 1'b1;
                n_len  = n_len + 2'd1;

                // leftover padding from a finished quad
                if (r_qpos == 2'd0 && r_pad != 2'd0) begin
                    if (n_err == ST_OK) n_err = ST_BAD_PAD;
                    n_pad = '0;
                end

                if (i_char_code == "=") begin
                    if (r_qpos < 2'd2) begin
                        if (n_err == ST_OK) n_err = ST_BAD_PAD;
                    end else begin
                        n_pad = n_pad + 2'd1;
                    end
                end else if (n_pad != 2'd0) begin
                    if (n_err == ST_OK) n_err = ST_BAD_PAD;
                end else if (v[6]) begin
                    if (n_err == ST_OK) n_err = ST_BAD_CHAR;
                end else begin
                    sx = v[5:0];
                end

                if (r_qpos != 2'd3) begin
                    n_acc  = {r_acc[11:0], sx};
                    n_qpos = r_qpos + 2'd1;
                end else begin
                    n_acc  = '0;
                    n_qpos = '0;
                    want   = (n_pad > 2'd2) ? 2'd1 : 2'd3 - n_pad;
                    if (n_err == ST_OK) begin
                        room = (r_bp >= cap) ? 13'd0 : cap - r_bp;
                        if (room < {11'd0, want}) begin
                            nout  = room[1:0];
                            n_err = ST_OVERFLOW;
                        end else begin
                            nout = want;
                        end
                        n_bp = r_bp + {11'd0, nout};
                    end
                    o_push       = (nout != 2'd0);
                    o_job.triple = {r_acc, sx};
                    o_job.nbytes = nout;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_acc  <= '0;
            r_qpos <= '0;
            r_pad  <= '0;
            r_len  <= '0;
            r_nlr  <= '0;
            r_seen <= 1'b0;
            r_tail <= 1'b0;
            r_err  <= ST_OK;
            r_bp   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_out_capacity;
            end
            r_acc  <= n_acc;
            r_qpos <= n_qpos;
            r_pad  <= n_pad;
            r_len  <= n_len;
            r_nlr  <= n_nlr;
            r_seen <= n_seen;
            r_tail <= n_tail;
            r_err  <= n_err;
            r_bp   <= n_bp;
        end
    end

endmodule
`default_nettype wire

FILE: design/sb64_back.sv
`default_nettype none
module sb64_back
    import sb64_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job      i_job,
    input  wire t_q_status i_q,
    output logic           o_pop,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output logic           o_kind,
    output logic [7:0]     o_data_byte,
    output logic [2:0]     o_status,
    output logic [12:0]    o_byte_count,
    output logic           o_last
);

    logic        r_out_valid;
    logic        r_kind;
    logic [7:0]  r_data;
    logic [2:0]  r_status;
    logic [12:0] r_count;
    logic [1:0]  r_idx;

    logic        load;
    logic [7:0]  sel_byte;

    assign load  = !i_q.empty && (!r_out_valid || i_out_ready);
    assign o_pop = load && (i_job.is_end || r_idx == i_job.nbytes - 2'd1);

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_job.triple[23:16];
            2'd1:    sel_byte = i_job.triple[15:8];
            default: sel_byte = i_job.triple[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= o_pop ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= i_job.is_end;
            r_data   <= i_job.is_end ? 8'd0 : sel_byte;
            r_status <= i_job.is_end ? i_job.status : ST_OK;
            r_count  <= i_job.is_end ? i_job.count : 13'd0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_data_byte  = r_data;
    assign o_status     = r_status;
    assign o_byte_count = r_count;
    assign o_last       = r_kind;

endmodule
`default_nettype wire

FILE: design/strict_base64_decoder.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+---------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_char_code, i_is_end
// out      | output    | o_out_valid / i_out_ready  | o_kind, o_data_byte, o_status,
//          |           |                            | o_byte_count, o_last
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_out_capacity
//
// One character is taken per cycle while the job queue is not full; a decoded
// byte or end status is loaded into the output register from the head of the queue.
// The back end sends one result per cycle, so a quad (4 transfers in, up to
// 3 out) never backs up the 4-entry job queue unless the sink stalls.
// Reset is synchronous, active low; out_capacity returns to 64.
// A stalled output holds its transfer; the front keeps going until the queue fills.
`default_nettype none
module strict_base64_decoder
    import sb64_pkg::*;
#(
    parameter int MAX_CAPACITY = 4096
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_is_end,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_kind,
    output logic [7:0]       o_data_byte,
    output logic [2:0]       o_status,
    output logic [12:0]      o_byte_count,
    output logic             o_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [12:0] i_out_capacity,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready
);

    t_job      push_job;
    t_job      head_job;
    t_q_status q_stat;
    logic      push;
    logic      pop;

    // capacity register is always writable
    assign o_cfg_ready = 1'b1;

    // front: classify characters, fold sextets, decide bytes and overflow
    sb64_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_code    (i_char_code),
        .i_is_end       (i_is_end),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_out_capacity (i_out_capacity),
        .i_cfg_valid    (i_cfg_valid),
        .i_q            (q_stat),
        .o_push         (push),
        .o_job          (push_job)
    );

    // jobs in flight between front and back
    sb64_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_stat)
    );

    // back: serialize each job into byte transfers or one status transfer
    sb64_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_q          (q_stat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_status     (o_status),
        .o_byte_count (o_byte_count),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

FILE: verif/tb_strict_base64_decoder.sv
`timescale 1ns / 100ps
module tb_strict_base64_decoder;
    import sb64_pkg::*;

    localparam int MAX_CAP       = 4096;
    localparam int SETTLE_CYCLES = 16;      // queue depth plus output register, with margin
    localparam int DRAIN_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 300;     // long sink hold-off, fills the job queue
    localparam int PHASE_ITEMS   = 90;
    localparam int DIR_ROWS      = 29;
    localparam int TIMEOUT_NS    = 6000000;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_PAD = 8'h3D;  // '='

    // One decoder output transfer
    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [12:0] byte_count;
        logic        last;
    } t_dec_result;

    // One row of the directed table: a character, an end item, or a capacity write
    typedef struct packed {
        logic        wr_cap;
        logic [12:0] cap;
        logic [7:0]  ch;
        logic        fin;
        logic        typed;     // st/cnt hold the end status, typed in by hand
        logic [2:0]  st;
        logic [12:0] cnt;
    } t_dir_row;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic [7:0]  in_char   = 8'd0;
    logic        in_end    = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    logic [12:0] cfg_cap   = CAP_RESET;
    logic        cfg_valid = 1'b0;

    wire logic        o_in_ready;
    wire logic        o_kind;
    wire logic [7:0]  o_data_byte;
    wire logic [2:0]  o_status;
    wire logic [12:0] o_byte_count;
    wire logic        o_last;
    wire logic        o_out_valid;
    wire logic        o_cfg_ready;

    strict_base64_decoder #(
        .MAX_CAPACITY(MAX_CAP)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_char_code    (in_char),
        .i_is_end       (in_end),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_status       (o_status),
        .o_byte_count   (o_byte_count),
        .o_last         (o_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .i_out_capacity (cfg_cap),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder shadow state
    // ------------------------------------------------------------------
    logic [17:0] acc;           // first three sextets of the open quad
    logic [1:0]  qpos;
    logic [1:0]  pads;          // '=' seen in the open or last closed quad
    logic [1:0]  len4;          // text length mod 4, trailing CR/LF run excluded
    logic [1:0]  nlrun;
    logic        seen;
    logic        in_nl;
    logic [2:0]  first_err;
    logic [12:0] nbytes;
    logic [12:0] capacity;

    t_dec_result decoded_q [$];     // decoder outputs still owed by the DUT

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    task automatic clear_text();
        acc       = '0;
        qpos      = '0;
        pads      = '0;
        len4      = '0;
        nlrun     = '0;
        seen      = 1'b0;
        in_nl     = 1'b0;
        first_err = ST_OK;
        nbytes    = '0;
    endtask

    // only the first error of a text is kept
    task automatic note_error(input logic [2:0] code);
        if (first_err == ST_OK)
            first_err = code;
    endtask

    // 64 flags a character outside the alphabet
    function automatic logic [6:0] sextet_of_char(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 7'(c - "A");
        if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
        if (c == "+") return 7'd62;
        if (c == "/") return 7'd63;
        return 7'd64;
    endfunction

    // Fold one accepted item into the shadow state, queueing what it yields
    task automatic decode_step(input logic [7:0] c, input logic fin);
        t_dec_result r;
        logic [5:0]  sx;
        logic [6:0]  v;
        logic [23:0] triple;
        logic [12:0] cap_eff;
        int          count;
        r = '0;
        if (fin) begin
            r.kind       = 1'b1;
            r.status     = (!seen || len4 != 2'd0) ? ST_BAD_LENGTH : first_err;
            r.byte_count = nbytes;
            r.last       = 1'b1;
            decoded_q.push_back(r);
            clear_text();
        end else if (c == CH_CR || c == CH_LF) begin
            if (!in_nl) begin
                in_nl = 1'b1;
                nlrun = 2'd0;
            end
            nlrun = nlrun + 2'd1;
        end else begin
            // data after a CR/LF run: the run counts toward the length
            if (in_nl) begin
                if (pads != 2'd0)
                    note_error(ST_BAD_PAD);
                note_error(ST_AFTER_NL);
                len4  = len4 + nlrun;
                in_nl = 1'b0;
                nlrun = 2'd0;
            end
            seen = 1'b1;
            len4 = len4 + 2'd1;
            // anything after a closed padded quad
            if (qpos == 2'd0 && pads != 2'd0) begin
                note_error(ST_BAD_PAD);
                pads = 2'd0;
            end
            sx = '0;
            if (c == CH_PAD) begin
                if (qpos < 2'd2)
                    note_error(ST_BAD_PAD);
                else
                    pads = pads + 2'd1;
            end else if (pads != 2'd0) begin
                note_error(ST_BAD_PAD);
            end else begin
                v = sextet_of_char(c);
                if (v > 7'd63)
                    note_error(ST_BAD_CHAR);
                else
                    sx = v[5:0];
            end
            if (qpos < 2'd3) begin
                acc  = {acc[11:0], sx};
                qpos = qpos + 2'd1;
            end else begin
                triple  = {acc, sx};
                cap_eff = (capacity > 13'(MAX_CAP)) ? 13'(MAX_CAP) : capacity;
                count   = 3 - ((pads > 2'd2) ? 2 : int'(pads));
                qpos    = 2'd0;
                acc     = '0;
                // bytes go out one by one until an error stops them
                for (int j = 0; j < count && first_err == ST_OK; j++) begin
                    if (nbytes >= cap_eff) begin
                        note_error(ST_OVERFLOW);
                    end else begin
                        r.data_byte = triple[23 - 8*j -: 8];
                        decoded_q.push_back(r);
                        nbytes = nbytes + 13'd1;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] b64_char();
        int idx;
        idx = $urandom_range(0, 63);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        return (idx == 62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic logic [7:0] nl_char();
        return ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF;
    endfunction

    function automatic t_dir_row row_ch(input logic [7:0] c);
        t_dir_row r;
        r    = '0;
        r.ch = c;
        return r;
    endfunction

    function automatic t_dir_row row_end(input logic [2:0] st, input logic [12:0] cnt);
        t_dir_row r;
        r       = '0;
        r.fin   = 1'b1;
        r.typed = 1'b1;
        r.st    = st;
        r.cnt   = cnt;
        return r;
    endfunction

    function automatic t_dir_row row_cap(input logic [12:0] v);
        t_dir_row r;
        r        = '0;
        r.wr_cap = 1'b1;
        r.cap    = v;
        return r;
    endfunction

    // Offer one item and hold it until the transfer; valid is left high when
    // no gap follows so back-to-back items never drop it for a step.
    task automatic send_item(input logic [7:0] c, input logic fin, input logic typed,
                             input logic [2:0] st, input logic [12:0] cnt);
        int gap;
        in_char  <= c;
        in_end   <= fin;
        in_valid <= 1'b1;
        do @(posedge clk); while (o_in_ready !== 1'b1);
        decode_step(c, fin);
        if (typed)
            decoded_q[decoded_q.size() - 1] = '{kind: 1'b1, data_byte: 8'd0, status: st,
                                                byte_count: cnt, last: 1'b1};
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every owed result has come out
    task automatic drain_results();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (decoded_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (decoded_q.size() != 0) begin
            $display("%0t: results outstanding, expected 0, actual %0d",
                     $time, decoded_q.size());
            errors++;
            decoded_q.delete();
        end
        // a quad closed under an error yields nothing but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [12:0] v);
        drain_results();
        cfg_cap   <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (o_cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        capacity = v;
    endtask

    // One random text plus its end item. Mostly clean quads with random
    // content; some get one defect, a few are pure noise.
    task automatic send_random_text(inout int items);
        logic [7:0] txt [$];
        int         r;
        int         nq;
        int         pos;
        int         npad;
        r  = $urandom_range(0, 99);
        nq = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
        for (int i = 0; i < 4 * nq; i++)
            txt.push_back(b64_char());
        if (r < 75) begin
            npad = $urandom_range(0, 2);
            if (npad > 0) txt[txt.size() - 1] = CH_PAD;
            if (npad > 1) txt[txt.size() - 2] = CH_PAD;
        end
        if (r >= 60 && r < 85) begin
            pos = $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 4))
                0: txt[pos] = 8'($urandom_range(0, 255));
                1: txt[pos] = CH_PAD;
                2: txt.insert(pos, nl_char());
                3: txt.delete(pos);
                default: begin
                    // newline then another quad, after a possibly padded one
                    txt.push_back(CH_LF);
                    repeat (4) txt.push_back(b64_char());
                end
            endcase
        end else if (r >= 85) begin
            txt.delete();
            repeat ($urandom_range(0, 10)) begin
                case ($urandom_range(0, 4))
                    0: txt.push_back(8'($urandom_range(0, 255)));
                    1: txt.push_back(CH_PAD);
                    2: txt.push_back(nl_char());
                    default: txt.push_back(b64_char());
                endcase
            end
        end
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) txt.push_back(nl_char());
        foreach (txt[k])
            send_item(txt[k], 1'b0, 1'b0, ST_OK, 13'd0);
        // char_code is don't-care on the end item, so randomize it
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, ST_OK, 13'd0);
        items += txt.size() + 1;
    endtask

    // ------------------------------------------------------------------
    // Output side: random ready, long hold-off on request, in-order check
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    initial begin : result_sink
        t_dec_result want;
        forever begin
            @(posedge clk);
            if (rst_n && out_ready && o_out_valid === 1'b1) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: extra transfer, expected none, actual %0d/%0d/%0d/%0d/%0d",
                             $time, o_kind, o_data_byte, o_status, o_byte_count, o_last);
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("data_byte", want.data_byte, o_data_byte);
                    check_field("status", want.status, o_status);
                    check_field("byte_count", want.byte_count, o_byte_count);
                    check_field("last", want.last, o_last);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_dir_row    dir_table [DIR_ROWS];
        t_dir_row    row;
        int          items;
        logic [12:0] new_cap;
        logic        paused;

        clear_text();
        capacity = CAP_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset capacity first, then capacity 1 for overflow
        dir_table = '{
            row_end(ST_BAD_LENGTH, 13'd0),                          // empty text
            row_ch("T"), row_ch("W"), row_ch("E"), row_ch(CH_PAD),  // one pad, 2 bytes
            row_ch(CH_CR), row_ch(CH_LF),                           // stripped tail
            row_end(ST_OK, 13'd2),
            row_ch("A"), row_ch(8'h00), row_ch(CH_PAD), row_ch("B"), // bad char wins
            row_end(ST_BAD_CHAR, 13'd0),
            row_ch(CH_PAD), row_ch(8'hFF), row_ch("/"), row_ch("+"), // pad too early
            row_end(ST_BAD_PAD, 13'd0),
            row_ch("z"), row_ch(CH_LF), row_ch("9"), row_ch("+"),    // newline then data
            row_end(ST_AFTER_NL, 13'd0),
            row_cap(13'd1),
            row_ch("/"), row_ch("/"), row_ch("+"), row_ch("/"),      // 2nd byte overflows
            row_end(ST_OVERFLOW, 13'd1)
        };
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        foreach (dir_table[i]) begin
            row = dir_table[i];
            if (row.wr_cap)
                write_capacity(row.cap);
            else
                send_item(row.ch, row.fin, row.typed, row.st, row.cnt);
        end

        // Random phases: each sets a capacity and an idling pattern
        paused = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       new_cap = 13'(MAX_CAP);
                1:       new_cap = 13'($urandom_range(2, 12));
                2:       new_cap = 13'd1;
                default: new_cap = 13'($urandom_range(13, MAX_CAP));
            endcase
            write_capacity(new_cap);
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            // sink holds off while the sender keeps going: queue fills, input stalls
            if (ph == 0)
                hold_left = HOLD_CYCLES;
            items = 0;
            while (items < PHASE_ITEMS) begin
                send_random_text(items);
                // in phase 2 the sender waits once, mid-phase, for every owed result
                if (ph == 2 && !paused && items >= PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        if (errors == 0)
            $display("strict_base64_decoder test passed");
        else
            $display("strict_base64_decoder test failed");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("strict_base64_decoder test failed");
        $finish;
    end

endmodule

FILE: files.f
design/sb64_pkg.sv
design/sb64_fifo.sv
design/sb64_front.sv
design/sb64_back.sv
design/strict_base64_decoder.sv
verif/tb_strict_base64_decoder.sv
